@@ rtl/frgq_pkg.sv @@
package frgq_pkg;

    typedef enum logic [2:0] {
        OP_ENQUEUE = 3'd0,
        OP_SET_FRAME = 3'd1,
        OP_FENCE_SIGNAL = 3'd2,
        OP_PROCESS = 3'd3,
        OP_FLUSH = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACK = 2'd0,
        KIND_RELEASED = 2'd1,
        KIND_NONE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_MAX_FRAMES = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_PRESSURE_EN = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    localparam logic [15:0] MAX_FRAMES_RST = 16'd3;
    localparam logic [7:0] THRESHOLD_RST = 8'd16;

    typedef struct packed {
        logic [31:0] handle;
        logic        present;
        logic [2:0]  id;
        logic [63:0] target;
        logic [63:0] stamp;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

@@ rtl/frgq_cell.sv @@
module frgq_cell (
    input  logic              clk,
    input  frgq_pkg::cell_ctl_t ctl,
    input  frgq_pkg::entry_t  load_data,
    input  frgq_pkg::entry_t  next_data,
    output frgq_pkg::entry_t  data
);
    import frgq_pkg::*;

    entry_t data_reg;
    entry_t data_next;

    // an append overrides the shift into this slot
    always_comb
    begin
        data_next = data_reg;
        if (ctl.load)
        begin
            data_next = load_data;
        end
        else if (ctl.shift)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ rtl/fence_gated_deferred_release_queue.sv @@
// Deferred release queue, gated by fence completion or frame age.
// Commands: pulse start with opcode and operands while busy is low; the
// command is taken on that edge. Every command yields one or more result
// beats, each shown for one cycle with strobe high; last marks the final
// beat. The receiver cannot stall, so results are never held back.
// Enqueue, set frame, fence signal and unused opcodes answer in the cycle
// after start and leave busy low, so such commands may issue every cycle.
// Process and flush walk the entry chain one entry per cycle at the head
// cell: a first pass counts ready entries and, if there are any, a second
// pass emits and compacts them. Busy stays high through both passes, or
// through the first alone when nothing is released, the nothing-released
// beat showing as busy falls. An empty table answers in the cycle after
// start with busy left low. Released beats come from the second pass, and
// the chain length QUEUE_DEPTH sets the longest walk.
// Registers sit on an APB port: 0x0 max deferred frames, 0x4 pressure
// threshold, 0x8 pressure enable. Reset empties the table, zeroes the
// frame and all fence values and loads register defaults 3, 16 and 0.
module fence_gated_deferred_release_queue #(
    parameter int QUEUE_DEPTH = 32,
    parameter int FENCE_COUNT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [31:0] resource_handle,
    input  logic        fence_present,
    input  logic [2:0]  fence_id,
    input  logic [63:0] fence_value,
    input  logic [63:0] frame_value,
    output logic        strobe,
    output logic [1:0]  result_kind,
    output logic [31:0] released_handle,
    output logic [1:0]  pressure_level,
    output logic        overflow,
    output logic [5:0]  pending_count,
    output logic [5:0]  released_count,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import frgq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int FSTORE = (FENCE_COUNT < 8) ? FENCE_COUNT : 8;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [CW-1:0] nrel_reg, nrel_next;
    logic [CW-1:0] rcnt_reg, rcnt_next;
    logic flush_reg, flush_next;
    logic [63:0] frame_reg, frame_next;
    logic [63:0] fence_reg [FSTORE];
    logic [15:0] mdf_reg;
    logic [7:0] thr_reg;
    logic pen_reg;

    logic strobe_reg, strobe_next;
    logic [1:0] kind_reg, kind_next;
    logic [31:0] handle_reg, handle_next;
    logic [1:0] level_reg, level_next;
    logic ovf_reg, ovf_next;
    logic [5:0] pend_reg, pend_next;
    logic [5:0] rel_reg, rel_next;
    logic last_reg, last_next;

    entry_t cell_q [QUEUE_DEPTH];
    cell_ctl_t cell_ctl [QUEUE_DEPTH];
    entry_t load_data;
    logic shift_en;
    logic load_en;
    logic [IW-1:0] load_idx;

    logic accept;
    op_t op;
    entry_t head;
    logic [63:0] head_done;
    logic frame_ok;
    logic ready_head;
    logic [CW-1:0] nfin;
    logic [CW-1:0] rcnt_inc;
    logic [CW-1:0] append_pos;
    logic [10:0] fill;
    logic [10:0] thr1, thr2, thr4;
    logic [1:0] enq_level;
    logic cfg_wr;

    assign busy = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign op = op_t'(opcode);
    assign head = cell_q[0];

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            entry_t nxt;
            if (g == QUEUE_DEPTH - 1)
            begin : g_tail
                assign nxt = cell_q[g];
            end
            else
            begin : g_body
                assign nxt = cell_q[g + 1];
            end
            assign cell_ctl[g].shift = shift_en;
            assign cell_ctl[g].load = load_en && (load_idx == IW'(g));
            frgq_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl[g]),
                .load_data (load_data),
                .next_data (nxt),
                .data      (cell_q[g])
            );
        end
    endgenerate

    // completed value of the head's fence; unknown ids read as zero
    always_comb
    begin
        head_done = 64'd0;
        for (int f = 0; f < FSTORE; f++)
        begin
            if (head.id == 3'(f))
            begin
                head_done = fence_reg[f];
            end
        end
    end

    assign frame_ok = (frame_reg >= head.stamp) &&
                      ((frame_reg - head.stamp) >= {48'd0, mdf_reg});
    assign ready_head = flush_reg ||
                        (head.present ? (head_done >= head.target) : frame_ok);
    assign nfin = nrel_reg + CW'(ready_head);
    assign rcnt_inc = rcnt_reg + CW'(1);
    assign append_pos = left_reg + kept_reg - CW'(1);

    assign fill = 11'(count_reg) + 11'd1;
    assign thr1 = {3'd0, thr_reg};
    assign thr2 = {2'd0, thr_reg, 1'b0};
    assign thr4 = {1'b0, thr_reg, 2'b00};

    always_comb
    begin
        enq_level = 2'd0;
        if (pen_reg && (fill >= thr1))
        begin
            if (fill >= thr4)
            begin
                enq_level = 2'd3;
            end
            else if (fill >= thr2)
            begin
                enq_level = 2'd2;
            end
            else
            begin
                enq_level = 2'd1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_PROCESS || op == OP_FLUSH) && count_reg != '0)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (left_reg == CW'(1))
                begin
                    state_next = (nfin == '0) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (left_reg == CW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        left_next = left_reg;
        kept_next = kept_reg;
        nrel_next = nrel_reg;
        rcnt_next = rcnt_reg;
        flush_next = flush_reg;
        frame_next = frame_reg;
        shift_en = 1'b0;
        load_en = 1'b0;
        load_idx = count_reg[IW-1:0];
        load_data = head;
        strobe_next = 1'b0;
        kind_next = KIND_ACK;
        handle_next = 32'd0;
        level_next = 2'd0;
        ovf_next = 1'b0;
        pend_next = 6'(count_reg);
        rel_next = 6'd0;
        last_next = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    case (op)
                        OP_ENQUEUE:
                        begin
                            if (count_reg >= CW'(QUEUE_DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                load_en = 1'b1;
                                load_data.handle = resource_handle;
                                load_data.present = fence_present;
                                load_data.id = fence_id;
                                load_data.target = fence_value;
                                load_data.stamp = frame_reg;
                                count_next = count_reg + CW'(1);
                                pend_next = 6'(count_next);
                                level_next = enq_level;
                            end
                        end
                        OP_SET_FRAME:
                        begin
                            frame_next = frame_value;
                        end
                        OP_PROCESS, OP_FLUSH:
                        begin
                            flush_next = (op == OP_FLUSH);
                            if (count_reg == '0)
                            begin
                                kind_next = KIND_NONE;
                            end
                            else
                            begin
                                strobe_next = 1'b0;
                                left_next = count_reg;
                                kept_next = '0;
                                nrel_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // rotate every entry back to the tail, count ready ones
                shift_en = 1'b1;
                load_en = 1'b1;
                load_idx = append_pos[IW-1:0];
                nrel_next = nfin;
                left_next = left_reg - CW'(1);
                kept_next = kept_reg + CW'(1);
                if (left_reg == CW'(1))
                begin
                    left_next = count_reg;
                    kept_next = '0;
                    rcnt_next = '0;
                    if (nfin == '0)
                    begin
                        strobe_next = 1'b1;
                        kind_next = KIND_NONE;
                    end
                end
            end
            ST_EMIT:
            begin
                // drop ready entries, append the rest behind the kept ones
                shift_en = 1'b1;
                load_idx = append_pos[IW-1:0];
                left_next = left_reg - CW'(1);
                if (ready_head)
                begin
                    strobe_next = 1'b1;
                    kind_next = KIND_RELEASED;
                    handle_next = head.handle;
                    pend_next = 6'(count_reg - nrel_reg);
                    rel_next = 6'(rcnt_inc);
                    last_next = (rcnt_inc == nrel_reg);
                    rcnt_next = rcnt_inc;
                end
                else
                begin
                    load_en = 1'b1;
                    kept_next = kept_reg + CW'(1);
                end
                if (left_reg == CW'(1))
                begin
                    count_next = count_reg - nrel_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            left_reg <= '0;
            kept_reg <= '0;
            nrel_reg <= '0;
            rcnt_reg <= '0;
            flush_reg <= 1'b0;
            frame_reg <= 64'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg <= left_next;
            kept_reg <= kept_next;
            nrel_reg <= nrel_next;
            rcnt_reg <= rcnt_next;
            flush_reg <= flush_next;
            frame_reg <= frame_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        handle_reg <= handle_next;
        level_reg <= level_next;
        ovf_reg <= ovf_next;
        pend_reg <= pend_next;
        rel_reg <= rel_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < FSTORE; f++)
            begin
                fence_reg[f] <= 64'd0;
            end
        end
        else if (accept && op == OP_FENCE_SIGNAL)
        begin
            for (int f = 0; f < FSTORE; f++)
            begin
                if (fence_id == 3'(f))
                begin
                    fence_reg[f] <= fence_value;
                end
            end
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mdf_reg <= MAX_FRAMES_RST;
            thr_reg <= THRESHOLD_RST;
            pen_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_MAX_FRAMES: mdf_reg <= pwdata[15:0];
                REG_THRESHOLD: thr_reg <= pwdata[7:0];
                REG_PRESSURE_EN: pen_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_MAX_FRAMES: prdata = {16'd0, mdf_reg};
            REG_THRESHOLD: prdata = {24'd0, thr_reg};
            REG_PRESSURE_EN: prdata = {31'd0, pen_reg};
            default: prdata = 32'd0;
        endcase
    end

    assign strobe = strobe_reg;
    assign result_kind = kind_reg;
    assign released_handle = handle_reg;
    assign pressure_level = level_reg;
    assign overflow = ovf_reg;
    assign pending_count = pend_reg;
    assign released_count = rel_reg;
    assign last = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == OP_PROCESS || op == OP_FLUSH) && count_reg != '0 |=> busy)
        else $error("process did not start walking the chain");

    a_rel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result_kind == KIND_RELEASED |-> released_count != 6'd0)
        else $error("released beat without a count");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> rcnt_reg <= nrel_reg)
        else $error("more releases than ready entries");
`endif

endmodule
